/* hdl/cie_pkg.sv */
package cie_pkg;

   localparam int CIE_OPCODE_W   = 4;
   localparam int CIE_VALUE_W    = 64;
   localparam int CIE_BYTE_W     = 8;
   localparam int CIE_QUEUE_DEPTH = 2;

   localparam logic [CIE_OPCODE_W-1:0] OP_INT    = 4'd0;
   localparam logic [CIE_OPCODE_W-1:0] OP_BYTES  = 4'd1;
   localparam logic [CIE_OPCODE_W-1:0] OP_TEXT   = 4'd2;
   localparam logic [CIE_OPCODE_W-1:0] OP_DOUBLE = 4'd3;
   localparam logic [CIE_OPCODE_W-1:0] OP_NULL   = 4'd4;
   localparam logic [CIE_OPCODE_W-1:0] OP_BOOL   = 4'd5;
   localparam logic [CIE_OPCODE_W-1:0] OP_MAP    = 4'd6;
   localparam logic [CIE_OPCODE_W-1:0] OP_LIST   = 4'd7;
   localparam logic [CIE_OPCODE_W-1:0] OP_BREAK  = 4'd8;
   localparam logic [CIE_OPCODE_W-1:0] OP_RAW    = 4'd9;

   localparam logic [2:0] MAJ_UINT  = 3'd0;
   localparam logic [2:0] MAJ_NINT  = 3'd1;
   localparam logic [2:0] MAJ_BYTES = 3'd2;
   localparam logic [2:0] MAJ_TEXT  = 3'd3;

   localparam logic [4:0] AI_ONE   = 5'd24;
   localparam logic [4:0] AI_TWO   = 5'd25;
   localparam logic [4:0] AI_FOUR  = 5'd26;
   localparam logic [4:0] AI_EIGHT = 5'd27;

   localparam logic [7:0] HEAD_DOUBLE = 8'hfb;
   localparam logic [7:0] HEAD_NULL   = 8'hf6;
   localparam logic [7:0] HEAD_FALSE  = 8'hf4;
   localparam logic [7:0] HEAD_TRUE   = 8'hf5;
   localparam logic [7:0] HEAD_MAP    = 8'hbf;
   localparam logic [7:0] HEAD_LIST   = 8'h9f;
   localparam logic [7:0] HEAD_BREAK  = 8'hff;

   // one token as the back end sees it: head byte, then nbytes taken from
   // the top of arg, most significant first
   typedef struct packed {
      logic [CIE_BYTE_W-1:0]  head;
      logic [CIE_VALUE_W-1:0] arg;
      logic [3:0]             nbytes;
   } desc_type;

endpackage

/* hdl/cie_if.sv */
interface cie_req_if import cie_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CIE_OPCODE_W-1:0] opcode;
   logic [CIE_VALUE_W-1:0]  value;

   modport source (output valid, opcode, value, input ready);
   modport sink (input valid, opcode, value, output ready);
endinterface

interface cie_rsp_if import cie_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CIE_BYTE_W-1:0] out_byte;
   logic                  last;

   modport source (output valid, out_byte, last, input ready);
   modport sink (input valid, out_byte, last, output ready);
endinterface

/* hdl/cbor_item_encoder_unit.sv */
// CBOR item encoder.
// req_if takes one token per transfer: opcode and a 64-bit value. rsp_if
// gives the encoded bytes one per transfer, head byte first and argument
// bytes most significant first; last marks the final byte of a token.
// Unused opcodes are taken and give no bytes.
// A token goes through a classifier into a short descriptor queue; the
// serialiser pops one descriptor and sends its bytes from an output register.
// A head byte is registered in the queue and then in the output register.
// The serialiser sends one byte per cycle while the receiver is ready; a token
// gives a head byte and n = 0, 1, 2, 4 or 8 argument bytes.
// Requests are taken while the queue has space, also while a byte waits.
// When the receiver stalls, the output byte holds, the serialiser stops and
// the queue fills; req_if.ready falls once the queue is full.
// Synchronous reset empties the queue and the output register and clears the
// serialiser's count of argument bytes left.
module cbor_item_encoder_unit import cie_pkg::*; #(
   parameter int QueueDepth = CIE_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   cie_req_if.sink   req_if,
   cie_rsp_if.source rsp_if
);

   logic     q_ready;
   logic     push;
   desc_type push_desc;
   logic     q_valid;
   logic     q_pop;
   desc_type q_desc;

   cie_front u_front (
      .req_if    (req_if),
      .q_ready   (q_ready),
      .push      (push),
      .push_desc (push_desc)
   );

   cie_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push),
      .in_ready  (q_ready),
      .in_desc   (push_desc),
      .out_valid (q_valid),
      .out_ready (q_pop),
      .out_desc  (q_desc)
   );

   cie_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_desc  (q_desc),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

   a_unused_dropped : assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && (req_if.opcode > OP_RAW)) |-> !push)
      else $error("unused opcode entered the queue");

   a_known_queued : assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && (req_if.opcode <= OP_RAW)) |=> q_valid)
      else $error("accepted token missing from the queue");

   a_pop_needs_slot : assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_if.valid)
      else $error("descriptor popped without a head byte");

endmodule

/* hdl/cie_front.sv */
module cie_front import cie_pkg::*; (
   cie_req_if.sink  req_if,
   input  logic     q_ready,
   output logic     push,
   output desc_type push_desc
);

   logic                   known;
   logic                   use_arg;
   logic [2:0]             major;
   logic [CIE_VALUE_W-1:0] arg;
   logic [7:0]             head;
   logic [3:0]             nbytes;
   logic [CIE_VALUE_W-1:0] aligned;

   always_comb begin
      known   = 1'b1;
      use_arg = 1'b0;
      major   = MAJ_UINT;
      arg     = req_if.value;
      head    = HEAD_BREAK;
      nbytes  = 4'd0;
      case (req_if.opcode)
         OP_INT: begin
            use_arg = 1'b1;
            if (req_if.value[CIE_VALUE_W-1]) begin
               major = MAJ_NINT;
               arg   = ~req_if.value;
            end
         end
         OP_BYTES: begin
            use_arg = 1'b1;
            major   = MAJ_BYTES;
         end
         OP_TEXT: begin
            use_arg = 1'b1;
            major   = MAJ_TEXT;
         end
         OP_DOUBLE: begin
            head   = HEAD_DOUBLE;
            nbytes = 4'd8;
         end
         OP_NULL:  head = HEAD_NULL;
         OP_BOOL:  head = req_if.value[0] ? HEAD_TRUE : HEAD_FALSE;
         OP_MAP:   head = HEAD_MAP;
         OP_LIST:  head = HEAD_LIST;
         OP_BREAK: head = HEAD_BREAK;
         OP_RAW:   head = req_if.value[7:0];
         default:  known = 1'b0;
      endcase

      // shortest argument form
      if (use_arg) begin
         if (arg < 64'd24) begin
            head = {major, arg[4:0]};
         end else if (arg < 64'd256) begin
            head   = {major, AI_ONE};
            nbytes = 4'd1;
         end else if (arg < 64'd65536) begin
            head   = {major, AI_TWO};
            nbytes = 4'd2;
         end else if (arg < 64'd4294967296) begin
            head   = {major, AI_FOUR};
            nbytes = 4'd4;
         end else begin
            head   = {major, AI_EIGHT};
            nbytes = 4'd8;
         end
      end

      case (nbytes)
         4'd1:    aligned = {arg[7:0], 56'd0};
         4'd2:    aligned = {arg[15:0], 48'd0};
         4'd4:    aligned = {arg[31:0], 32'd0};
         default: aligned = arg;
      endcase
   end

   assign req_if.ready     = q_ready;
   assign push             = req_if.valid && q_ready && known;
   assign push_desc.head   = head;
   assign push_desc.arg    = aligned;
   assign push_desc.nbytes = nbytes;

endmodule

/* hdl/cie_queue.sv */
module cie_queue import cie_pkg::*; #(
   parameter int Depth = CIE_QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  desc_type in_desc,
   output logic     out_valid,
   input  logic     out_ready,
   output desc_type out_desc
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   desc_type        mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            wr_en, rd_en;

   assign in_ready  = (count_ff != CntW'(Depth));
   assign out_valid = (count_ff != '0);
   assign out_desc  = mem_ff[rd_ptr_ff];
   assign wr_en     = in_valid && in_ready;
   assign rd_en     = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CntW'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= in_desc;
      end
   end

endmodule

/* hdl/cie_back.sv */
module cie_back import cie_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  desc_type q_desc,
   output logic     q_pop,
   cie_rsp_if.source rsp_if
);

   logic                   out_valid_ff, out_valid_in;
   logic [CIE_BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic                   out_last_ff, out_last_in;
   logic [CIE_VALUE_W-1:0] arg_ff, arg_in;
   logic [3:0]             left_ff, left_in;
   logic                   load_ok;

   assign load_ok = !out_valid_ff || rsp_if.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      arg_in       = arg_ff;
      left_in      = left_ff;
      q_pop        = 1'b0;
      if (load_ok) begin
         if (left_ff != 4'd0) begin
            out_valid_in = 1'b1;
            out_byte_in  = arg_ff[CIE_VALUE_W-1 -: CIE_BYTE_W];
            out_last_in  = (left_ff == 4'd1);
            arg_in       = {arg_ff[CIE_VALUE_W-CIE_BYTE_W-1:0], {CIE_BYTE_W{1'b0}}};
            left_in      = left_ff - 4'd1;
         end else if (q_valid) begin
            q_pop        = 1'b1;
            out_valid_in = 1'b1;
            out_byte_in  = q_desc.head;
            out_last_in  = (q_desc.nbytes == 4'd0);
            arg_in       = q_desc.arg;
            left_in      = q_desc.nbytes;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         left_ff      <= 4'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      arg_ff      <= arg_in;
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.out_byte = out_byte_ff;
   assign rsp_if.last     = out_last_ff;

endmodule

/* tb/tb_top.sv */
module tb_top;
   import cie_pkg::*;

   localparam int IDLE_PCT       = 31;
   localparam int RANDOM_TOKENS  = 430;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 20;

   typedef struct packed {
      logic [CIE_BYTE_W-1:0] data;
      logic                  last;
   } enc_byte_type;

   // n < 0: bytes come from the encoder model, else hand holds n bytes, first at the top
   typedef struct {
      logic [CIE_OPCODE_W-1:0] op;
      logic [CIE_VALUE_W-1:0]  val;
      int                      n;
      logic [71:0]             hand;
   } stim_row_type;

   logic clock;
   logic reset;

   cie_req_if req_ch ();
   cie_rsp_if rsp_ch ();

   cbor_item_encoder_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   enc_byte_type  cbor_bytes_due[$];
   stim_row_type  directed_rows[$];
   int         mismatch_count = 0;
   int         drive_n = -1;
   logic [71:0] drive_hand = '0;
   bit         steady = 0;
   int         hold_asks = 0;
   int         idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 100) $display("tb_top: mismatch: %s", what);
   endtask

   function automatic void encode_token(input logic [CIE_OPCODE_W-1:0] op,
                                        input logic [CIE_VALUE_W-1:0] val);
      logic [CIE_BYTE_W-1:0]  seq[$];
      logic [2:0]             major;
      logic [CIE_VALUE_W-1:0] arg;
      int                     extra;
      int                     i;
      bit                     headed;
      headed = 1'b0;
      major  = MAJ_UINT;
      arg    = val;
      extra  = 0;
      case (op)
         OP_INT: begin
            headed = 1'b1;
            if (val[63]) begin
               major = MAJ_NINT;
               arg   = ~val;
            end
         end
         OP_BYTES: begin
            headed = 1'b1;
            major  = MAJ_BYTES;
         end
         OP_TEXT: begin
            headed = 1'b1;
            major  = MAJ_TEXT;
         end
         OP_DOUBLE: begin
            seq.push_back(HEAD_DOUBLE);
            for (i = 7; i >= 0; i--) seq.push_back(val[8*i +: 8]);
         end
         OP_NULL:  seq.push_back(HEAD_NULL);
         OP_BOOL:  seq.push_back(val[0] ? HEAD_TRUE : HEAD_FALSE);
         OP_MAP:   seq.push_back(HEAD_MAP);
         OP_LIST:  seq.push_back(HEAD_LIST);
         OP_BREAK: seq.push_back(HEAD_BREAK);
         OP_RAW:   seq.push_back(val[7:0]);
         default: ;
      endcase
      if (headed) begin
         if (arg < 64'd24) begin
            seq.push_back({major, arg[4:0]});
         end else if (arg < 64'd256) begin
            seq.push_back({major, AI_ONE});
            extra = 1;
         end else if (arg < 64'd65536) begin
            seq.push_back({major, AI_TWO});
            extra = 2;
         end else if (arg < 64'h1_0000_0000) begin
            seq.push_back({major, AI_FOUR});
            extra = 4;
         end else begin
            seq.push_back({major, AI_EIGHT});
            extra = 8;
         end
         for (i = extra - 1; i >= 0; i--) seq.push_back(arg[8*i +: 8]);
      end
      foreach (seq[k]) cbor_bytes_due.push_back('{data: seq[k], last: (k == seq.size() - 1)});
   endfunction

   function automatic void add_row(input logic [CIE_OPCODE_W-1:0] op,
                                   input logic [CIE_VALUE_W-1:0] val,
                                   input int n, input logic [71:0] hand);
      stim_row_type r;
      r.op   = op;
      r.val  = val;
      r.n    = n;
      r.hand = hand;
      directed_rows.push_back(r);
   endfunction

   // argument of a random size class; for ints the top bit stays clear
   function automatic logic [CIE_VALUE_W-1:0] sized_arg(input bit for_int);
      logic [31:0] hi;
      case ($urandom_range(0, 4))
         0: return 64'($urandom_range(0, 23));
         1: return 64'($urandom_range(24, 255));
         2: return 64'($urandom_range(256, 65535));
         3: return 64'($urandom_range(65536, 32'hffffffff));
         default: begin
            hi = $urandom_range(1, 32'hffffffff);
            if (for_int) hi[31] = 1'b0;
            if (hi == 32'd0) hi = 32'd1;
            return {hi, 32'($urandom)};
         end
      endcase
   endfunction

   task automatic send_token(input logic [CIE_OPCODE_W-1:0] op,
                             input logic [CIE_VALUE_W-1:0] val,
                             input int n, input logic [71:0] hand);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid  = 1'b1;
      req_ch.opcode = op;
      req_ch.value  = val;
      drive_n       = n;
      drive_hand    = hand;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic drain;
      while (cbor_bytes_due.size() != 0) @(negedge clock);
   endtask

   // receiver
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen    = 0;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else if (steady) begin
            rsp_ch.ready = 1'b1;
         end else begin
            rsp_ch.ready = ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // predict on request transfers, check on response transfers
   always @(posedge clock) begin : monitor
      enc_byte_type due;
      int        i;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            if (drive_n >= 0) begin
               for (i = 0; i < drive_n; i++)
                  cbor_bytes_due.push_back('{data: drive_hand[8*(drive_n-1-i) +: 8],
                                             last: (i == drive_n - 1)});
            end else begin
               encode_token(req_ch.opcode, req_ch.value);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (cbor_bytes_due.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h last %0b",
                                         rsp_ch.out_byte, rsp_ch.last));
            end else begin
               due = cbor_bytes_due.pop_front();
               if (rsp_ch.out_byte !== due.data)
                  report_mismatch($sformatf("byte %02h, want %02h",
                                            rsp_ch.out_byte, due.data));
               if (rsp_ch.last !== due.last)
                  report_mismatch($sformatf("last %0b on byte %02h, want %0b",
                                            rsp_ch.last, rsp_ch.out_byte, due.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   initial begin
      int                      count;
      bit                      drained;
      logic [CIE_OPCODE_W-1:0] op;
      logic [CIE_VALUE_W-1:0]  val;

      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.opcode = '0;
      req_ch.value  = '0;

      add_row(OP_INT,    64'd0,                  1, 72'h00);
      add_row(OP_INT,    64'd24,                 2, 72'h1818);
      add_row(OP_INT,    64'd255,                2, 72'h18ff);
      add_row(OP_INT,    64'd256,                3, 72'h190100);
      add_row(OP_INT,    64'd65536,              5, 72'h1a00010000);
      add_row(OP_INT,    64'hffff_ffff,          5, 72'h1affffffff);
      add_row(OP_INT,    64'h1_0000_0000,        9, 72'h1b0000000100000000);
      add_row(OP_INT,    64'h7fff_ffff_ffff_ffff, 9, 72'h1b7fffffffffffffff);
      add_row(OP_INT,    64'hffff_ffff_ffff_ffff, 1, 72'h20);
      add_row(OP_INT,    64'hffff_ffff_ffff_ffe8, 1, 72'h37);
      add_row(OP_INT,    64'hffff_ffff_ffff_ffe7, 2, 72'h3818);
      add_row(OP_INT,    64'h8000_0000_0000_0000, 9, 72'h3b7fffffffffffffff);
      add_row(OP_BYTES,  64'd0,                  1, 72'h40);
      add_row(OP_TEXT,   64'd300,               -1, '0);
      add_row(OP_DOUBLE, 64'h0123_4567_89ab_cdef, 9, 72'hfb0123456789abcdef);
      add_row(OP_NULL,   64'hffff_ffff_ffff_ffff, 1, 72'hf6);
      add_row(OP_BOOL,   64'hffff_ffff_ffff_fffe, 1, 72'hf4);
      add_row(OP_BOOL,   64'hffff_ffff_ffff_ffff, 1, 72'hf5);
      add_row(OP_MAP,    64'hffff_ffff_ffff_ffff, 1, 72'hbf);
      add_row(OP_LIST,   64'h5555_aaaa_5555_aaaa, 1, 72'h9f);
      add_row(OP_BREAK,  64'd0,                  1, 72'hff);
      add_row(OP_RAW,    64'h0123_4567_89ab_cdef, 1, 72'hef);
      add_row(4'd10,     64'hffff_ffff_ffff_ffff, 0, '0);
      add_row(4'd15,     64'd0,                  0, '0);

      repeat (12) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[r])
         send_token(directed_rows[r].op, directed_rows[r].val,
                    directed_rows[r].n, directed_rows[r].hand);
      req_ch.valid = 1'b0;
      drain();

      count   = 0;
      drained = 1'b0;
      while (count < RANDOM_TOKENS) begin
         steady = (count >= 200 && count < 280);
         if (count == 120 && hold_asks == 0) hold_asks++;
         if (count == 350 && !drained) begin
            drained      = 1'b1;
            req_ch.valid = 1'b0;
            drain();
         end
         val = {32'($urandom), 32'($urandom)};
         if ($urandom_range(0, 99) < 5) begin
            op = 4'($urandom_range(10, 15));
         end else begin
            op = 4'($urandom_range(0, 9));
            count++;
            case (op)
               OP_INT: begin
                  val = sized_arg(1'b1);
                  if ($urandom_range(0, 1)) val = ~val;
               end
               OP_BYTES, OP_TEXT: val = sized_arg(1'b0);
               default: ;
            endcase
         end
         send_token(op, val, -1, '0);
      end
      steady       = 1'b0;
      req_ch.valid = 1'b0;
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

/* cbor_item_encoder_unit.f */
hdl/cie_pkg.sv
hdl/cie_if.sv
hdl/cie_front.sv
hdl/cie_queue.sv
hdl/cie_back.sv
hdl/cbor_item_encoder_unit.sv
tb/tb_top.sv
